FILE: rtl/accel_window_ring_buffer_assert.svh
`ifndef ACCEL_WINDOW_RING_BUFFER_ASSERT_SVH
`define ACCEL_WINDOW_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is high.
`define AWRB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is high.
`define AWRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/awrb_pkg.sv
package awrb_pkg;

  // Field widths
  localparam int RAW_W       = 12;
  localparam int KIND_W      = 2;
  localparam int INDEX_W     = 9;
  localparam int PERIOD_W    = 10;
  localparam int WLEN_W      = 9;
  localparam int VALUE_W     = 17;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;

  typedef logic [RAW_W-1:0]          raw_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 4'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd40;
  localparam logic [PERIOD_W-1:0] ELAPSED_MAX  = 10'd1023;
  localparam logic [WLEN_W-1:0]   WLEN_RESET   = 9'd300;

  // Scaling: q = round(|raw - 2330| * 1600 / 63) with sign restored.
  // The divide by 63 is a multiply by ceil(2^30 / 63), exact for
  // numerators below 2^22.
  localparam int MAG_W       = 12;
  localparam int NUM_W       = 22;
  localparam int RECIP_W     = 25;
  localparam int QMAG_W      = 16;
  localparam int RECIP_SHIFT = 30;
  localparam logic signed [RAW_W:0] ZERO_COUNT = 13'sd2330;
  localparam logic [NUM_W-1:0]   SCALE_NUM  = 22'd1600;
  localparam logic [NUM_W-1:0]   ROUND_BIAS = 22'd31;
  localparam logic [RECIP_W-1:0] RECIP      = 25'd17043522;

endpackage

FILE: rtl/awrb_sample_if.sv
interface awrb_sample_if;
  logic                          valid;
  logic                          ready;
  logic [awrb_pkg::KIND_W-1:0]   kind;
  awrb_pkg::raw_t                raw_x;
  awrb_pkg::raw_t                raw_y;
  awrb_pkg::raw_t                raw_z;
  logic [awrb_pkg::INDEX_W-1:0]  element_index;

  modport source (output valid, kind, raw_x, raw_y, raw_z, element_index, input ready);
  modport sink   (input valid, kind, raw_x, raw_y, raw_z, element_index, output ready);
endinterface

FILE: rtl/awrb_result_if.sv
interface awrb_result_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             ready_res;
  awrb_pkg::value_t read_value;

  modport source (output valid, accepted, ready_res, read_value, input ready);
  modport sink   (input valid, accepted, ready_res, read_value, output ready);
endinterface

FILE: rtl/awrb_cfg_if.sv
interface awrb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [awrb_pkg::CFG_INDEX_W-1:0]  index;
  logic [awrb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/accel_window_ring_buffer.sv
// Accelerometer window ring buffer.
// sample channel: kind 0 counts one millisecond, kind 1 offers three raw samples,
// kind 2 reads one element of the newest window_length stored values, kind 3 is
// a no-op. Every input transfer yields exactly one transfer on the result channel.
// cfg channel: index 0 sample_period_ms, index 1 window_length; always ready.
// Path from input transfer to result valid:
//   tick, rejected acquisition, no-op: S_RESP, then the output register
//   window read: S_RD_ADDR (address add, synchronous memory read), S_RD_DATA, S_RESP
//   accepted acquisition: S_ACQ, S_RESP; the scaler is a two-stage
//   pipeline fed one channel per cycle, and the memory takes one write per cycle.
// The result sits in an output register, so the next input is taken while a
// result waits; a stalled receiver holds the result and the block stalls at its
// next result. Reset sets the registers to 40 and 300, clears the tick count,
// the write position and the wrap mark. The sample memory is not swept: entries
// not yet written since reset (beyond the write position before the first wrap)
// read as zero, so the block is usable in the cycle after reset.
module accel_window_ring_buffer #(
  parameter int SAMPLES_PER_CHANNEL = 100,
  parameter int CHANNELS            = 3
) (
  input  logic            clk,
  input  logic            rst,
  awrb_sample_if.sink     sample,
  awrb_result_if.source   result,
  awrb_cfg_if.sink        cfg
);

  localparam int RING_SIZE = SAMPLES_PER_CHANNEL * CHANNELS;
  localparam int AW = $clog2(RING_SIZE);
  localparam int LW = $clog2(RING_SIZE + 1);
  localparam int SW = ((LW > awrb_pkg::INDEX_W) ? LW : awrb_pkg::INDEX_W) + 2;
  localparam int CW = $clog2(CHANNELS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACQ,
    S_RD_ADDR,
    S_RD_DATA,
    S_RESP
  } state_t;

  state_t                         state;
  logic [awrb_pkg::PERIOD_W-1:0]  period;
  logic [awrb_pkg::WLEN_W-1:0]    wlen;
  logic [awrb_pkg::PERIOD_W-1:0]  elapsed;
  logic [AW-1:0]                  wp;
  logic                           wrapped;
  logic                           filling;
  awrb_pkg::raw_t                 raw_x_q;
  awrb_pkg::raw_t                 raw_y_q;
  awrb_pkg::raw_t                 raw_z_q;
  logic [awrb_pkg::INDEX_W-1:0]   idx_q;
  logic [CW-1:0]                  issue_cnt;
  logic [CW-1:0]                  wr_cnt;
  logic                           rd_hit;
  logic                           res_acc;
  logic                           res_rdy;
  awrb_pkg::value_t               res_val;
  logic                           out_valid;
  logic                           out_acc;
  logic                           out_rdy;
  awrb_pkg::value_t               out_val;

  awrb_pkg::value_t               mem [RING_SIZE];
  awrb_pkg::value_t               mem_rdata;

  logic [SW-1:0]                  ring_ext;
  logic [SW-1:0]                  wlen_ext;
  logic [SW-1:0]                  wl_clamp;
  logic                           in_win;
  logic [SW-1:0]                  pos_sum;
  logic [SW-1:0]                  pos_wrap;
  logic [AW-1:0]                  rd_addr;
  logic                           entry_written;
  logic                           wp_last;
  logic [AW-1:0]                  wp_next;
  logic                           fill_done;
  logic                           issue_more;
  logic                           last_write;
  logic                           acq_ok;
  awrb_pkg::raw_t                 scale_raw;
  logic                           scale_in_valid;
  logic                           scale_valid;
  awrb_pkg::value_t               scale_value;

  // Window address: oldest element sits window_length entries (clamped to the ring
  // size) behind the write position.
  assign ring_ext = SW'(RING_SIZE);
  assign wlen_ext = SW'(wlen);
  assign wl_clamp = (wlen_ext > ring_ext) ? ring_ext : wlen_ext;
  assign in_win   = SW'(idx_q) < wl_clamp;
  assign pos_sum  = SW'(wp) + SW'(idx_q) + ring_ext - wl_clamp;
  assign pos_wrap = (pos_sum >= ring_ext) ? pos_sum - ring_ext : pos_sum;
  assign rd_addr  = in_win ? pos_wrap[AW-1:0] : '0;
  // entries past the write position are unwritten until the first wrap
  assign entry_written = wrapped || (pos_wrap < SW'(wp));

  assign wp_last    = (wp == AW'(RING_SIZE - 1));
  assign wp_next    = wp_last ? '0 : wp + 1'b1;
  assign fill_done  = LW'(wp_next) >= LW'(SAMPLES_PER_CHANNEL);
  assign issue_more = issue_cnt < CW'(CHANNELS);
  assign last_write = (wr_cnt == CW'(CHANNELS - 1));
  assign acq_ok     = elapsed >= period;

  assign scale_in_valid = (state == S_ACQ) && issue_more;

  always_comb begin
    case (issue_cnt)
      CW'(0):  scale_raw = raw_x_q;
      CW'(1):  scale_raw = raw_y_q;
      default: scale_raw = raw_z_q;
    endcase
  end

  awrb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scale_in_valid),
    .raw       (scale_raw),
    .out_valid (scale_valid),
    .value     (scale_value)
  );

  assign sample.ready      = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.accepted   = out_acc;
  assign result.ready_res  = out_rdy;
  assign result.read_value = out_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      period    <= awrb_pkg::PERIOD_RESET;
      wlen      <= awrb_pkg::WLEN_RESET;
      elapsed   <= '0;
      wp        <= '0;
      wrapped   <= 1'b0;
      filling   <= 1'b1;
      issue_cnt <= '0;
      wr_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          awrb_pkg::REG_SAMPLE_PERIOD: period <= cfg.data[awrb_pkg::PERIOD_W-1:0];
          awrb_pkg::REG_WINDOW_LENGTH: wlen   <= cfg.data[awrb_pkg::WLEN_W-1:0];
          default: ;
        endcase
      end

      // S_RESP reloads the output register itself
      if (result.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            res_acc <= 1'b0;
            res_rdy <= 1'b0;
            res_val <= '0;
            idx_q   <= sample.element_index;
            raw_x_q <= sample.raw_x;
            raw_y_q <= sample.raw_y;
            raw_z_q <= sample.raw_z;
            case (sample.kind)
              awrb_pkg::KIND_TICK: begin
                // saturate the tick count
                if (elapsed != awrb_pkg::ELAPSED_MAX) begin
                  elapsed <= elapsed + 1'b1;
                end
                state <= S_RESP;
              end
              awrb_pkg::KIND_ACQUIRE: begin
                if (acq_ok) begin
                  elapsed   <= '0;
                  issue_cnt <= '0;
                  wr_cnt    <= '0;
                  state     <= S_ACQ;
                end else begin
                  state <= S_RESP;
                end
              end
              awrb_pkg::KIND_READ: state <= S_RD_ADDR;
              default:             state <= S_RESP;
            endcase
          end
        end
        S_ACQ: begin
          if (issue_more) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (scale_valid) begin
            wp     <= wp_next;
            wr_cnt <= wr_cnt + 1'b1;
            if (wp_last) begin
              wrapped <= 1'b1;
            end
            if (last_write) begin
              if (fill_done) begin
                filling <= 1'b0;
              end
              res_acc <= 1'b1;
              res_rdy <= !filling || fill_done;
              state   <= S_RESP;
            end
          end
        end
        S_RD_ADDR: begin
          rd_hit <= in_win && entry_written;
          state  <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res_val <= rd_hit ? mem_rdata : '0;
          state   <= S_RESP;
        end
        S_RESP: begin
          // hold until the output register is free
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_acc   <= res_acc;
            out_rdy   <= res_rdy;
            out_val   <= res_val;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_ACQ) && scale_valid) begin
      mem[wp] <= scale_value;
    end
    if (state == S_RD_ADDR) begin
      mem_rdata <= mem[rd_addr];
    end
  end

  `include "accel_window_ring_buffer_assert.svh"

  `AWRB_ASSERT_SAME(a_rdy_needs_acc, clk, rst, result.valid && !result.accepted, !result.ready_res, "ready_res set on a result that was not accepted")
  `AWRB_ASSERT_NEXT(a_wp_only_in_acq, clk, rst, state != S_ACQ, $stable(wp), "write position moved outside an acquisition")
  `AWRB_ASSERT_SAME(a_rd_data_order, clk, rst, state == S_RD_DATA, $past(state) == S_RD_ADDR, "read data taken without a read issued the cycle before")

endmodule

FILE: rtl/awrb_scale.sv
module awrb_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  awrb_pkg::raw_t   raw,
  output logic             out_valid,
  output awrb_pkg::value_t value
);

  localparam int PROD_W = awrb_pkg::NUM_W + awrb_pkg::RECIP_W;

  logic signed [awrb_pkg::RAW_W:0] diff;
  logic [awrb_pkg::MAG_W-1:0]      mag;
  logic [awrb_pkg::NUM_W-1:0]      num_c;

  logic                            v1;
  logic                            neg1;
  logic [awrb_pkg::NUM_W-1:0]      num1;

  logic [PROD_W-1:0]               prod;

  logic                            v2;
  logic                            neg2;
  logic [awrb_pkg::QMAG_W-1:0]     qmag2;
  awrb_pkg::value_t                mag_s;

  assign diff  = $signed({1'b0, raw}) - awrb_pkg::ZERO_COUNT;
  assign mag   = diff[awrb_pkg::RAW_W] ? awrb_pkg::MAG_W'(-diff)
                                       : diff[awrb_pkg::MAG_W-1:0];
  // add half the divisor so the floor below rounds to nearest
  assign num_c = awrb_pkg::NUM_W'(mag) * awrb_pkg::SCALE_NUM + awrb_pkg::ROUND_BIAS;

  assign prod  = PROD_W'(num1) * PROD_W'(awrb_pkg::RECIP);

  assign mag_s = {1'b0, qmag2};
  assign value = neg2 ? -mag_s : mag_s;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    neg1  <= diff[awrb_pkg::RAW_W];
    num1  <= num_c;
    neg2  <= neg1;
    qmag2 <= prod[awrb_pkg::RECIP_SHIFT +: awrb_pkg::QMAG_W];
  end

endmodule
